[hw/rtl/alad_pkg.sv]
// alad_pkg: shared types, codes and defaults for the compact value list.
// Used by alad_store and array_list_append_delete; depends on nothing.

package alad_pkg;

  // Default store depth
  localparam int ALAD_DEPTH = 8;

  // Command codes
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  // Status codes
  localparam logic [2:0] STS_DONE     = 3'd0;
  localparam logic [2:0] STS_FULL     = 3'd1;
  localparam logic [2:0] STS_EMPTY    = 3'd2;
  localparam logic [2:0] STS_NOTFOUND = 3'd3;
  localparam logic [2:0] STS_READ     = 3'd4;

  // Input transfer
  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] value;
  } alad_in_t;

  // Result transfer
  typedef struct packed {
    logic [2:0]         status;
    logic [2:0]         position;
    logic signed [31:0] entry_value;
    logic [3:0]         count;
    logic               last;
  } alad_out_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SHIFT,
    ST_READ
  } alad_state_t;

endpackage

[hw/rtl/alad_store.sv]
// alad_store: entry memory with one write port, one registered read port
// and the shared equality comparator; depends on alad_pkg.

module alad_store #(
  parameter int DEPTH = alad_pkg::ALAD_DEPTH
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  logic signed [31:0]         wr_data,
  input  logic                       rd_en,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr,
  input  logic signed [31:0]         key,
  output logic signed [31:0]         rd_data,
  output logic                       match
);
  import alad_pkg::*;

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rd_data_r;

  // Write one entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Register the read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Compare the entry just read against the search key
  assign rd_data = rd_data_r;
  assign match   = (rd_data_r == key);

endmodule

[hw/rtl/array_list_append_delete.sv]
// array_list_append_delete: compact list of signed 32-bit values with
// append, delete-by-value and read out; depends on alad_pkg, alad_store.
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------
//  input    | start, busy          | in_item  (alad_in_t)
//  result   | out_valid (strobe)   | out_item (alad_out_t)
//
// Insert and every command on an empty list finish in ST_IDLE; the result
// shows in the cycle after the transfer and the next command is taken at once.
// Delete walks the memory's single read port: it searches up to the match
// or, on a miss, to the last entry; on a match it then moves each entry
// above it down by one place and finishes.
// Read out gives one result a cycle.
// Synchronous active-low reset empties the list; entries are not cleared.
// Results cannot be stalled: each out_valid pulse lasts one cycle.

module array_list_append_delete #(
  parameter int DEPTH = alad_pkg::ALAD_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  alad_pkg::alad_in_t  in_item,
  output logic                out_valid,
  output alad_pkg::alad_out_t out_item
);
  import alad_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  alad_state_t        state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic signed [31:0] key_r, key_nxt;
  logic [CW-1:0]      idx_r, idx_nxt;
  logic               chk_vld_r, chk_vld_nxt;
  logic [CW-1:0]      chk_idx_r, chk_idx_nxt;
  logic [AW-1:0]      pos_r, pos_nxt;
  logic               out_vld_r, out_vld_nxt;
  alad_out_t          out_r, out_nxt;

  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic signed [31:0] wr_data;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic signed [31:0] rd_data;
  logic               match;

  logic               accept;
  logic               rd_go;
  logic               chk_last;
  logic               hit;
  logic               miss;
  logic               shift_end;
  logic [CW-1:0]      cnt_inc;
  logic [CW-1:0]      cnt_dec;
  logic [CW-1:0]      src_dec;
  logic [CW-1:0]      src_inc;

  assign accept    = start && (state_r == ST_IDLE);
  assign busy      = (state_r != ST_IDLE);
  assign cnt_inc   = count_r + CW'(1);
  assign cnt_dec   = count_r - CW'(1);
  assign src_dec   = chk_idx_r - CW'(1);
  assign src_inc   = chk_idx_r + CW'(1);
  assign rd_go     = (idx_r < count_r);
  assign chk_last  = chk_vld_r && (chk_idx_r == cnt_dec);
  assign hit       = chk_vld_r && match;
  assign miss      = chk_last && !match;
  assign shift_end = !chk_vld_r && !rd_go;

  alad_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .key     (key_r),
    .rd_data (rd_data),
    .match   (match)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && (count_r != '0)) begin
          if (in_item.cmd == CMD_DELETE) begin
            state_nxt = ST_SEARCH;
          end else if (in_item.cmd == CMD_READ) begin
            state_nxt = ST_READ;
          end
        end
      end
      ST_SEARCH: begin
        if (hit) begin
          state_nxt = ST_SHIFT;
        end else if (miss) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SHIFT: begin
        if (shift_end) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_READ: begin
        if (chk_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath, memory port and result
  always_comb begin
    count_nxt   = count_r;
    key_nxt     = key_r;
    idx_nxt     = idx_r;
    chk_vld_nxt = 1'b0;
    chk_idx_nxt = chk_idx_r;
    pos_nxt     = pos_r;
    out_vld_nxt = 1'b0;
    out_nxt     = out_r;
    wr_en       = 1'b0;
    wr_addr     = count_r[AW-1:0];
    wr_data     = in_item.value;
    rd_en       = 1'b0;
    rd_addr     = idx_r[AW-1:0];
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_nxt.position    = '0;
          out_nxt.entry_value = in_item.value;
          out_nxt.count       = 4'(count_r);
          out_nxt.last        = 1'b1;
          case (in_item.cmd)
            CMD_INSERT: begin
              out_vld_nxt = 1'b1;
              if (count_r == CW'(DEPTH)) begin
                out_nxt.status = STS_FULL;
              end else begin
                // Append after the last held entry
                wr_en            = 1'b1;
                count_nxt        = cnt_inc;
                out_nxt.status   = STS_DONE;
                out_nxt.position = 3'(count_r);
                out_nxt.count    = 4'(cnt_inc);
              end
            end
            CMD_DELETE, CMD_READ: begin
              if (count_r == '0) begin
                out_vld_nxt    = 1'b1;
                out_nxt.status = STS_EMPTY;
                if (in_item.cmd == CMD_READ) begin
                  out_nxt.entry_value = '0;
                end
              end else begin
                key_nxt = in_item.value;
                idx_nxt = '0;
              end
            end
            default: begin
              // Unused command: drop it
              out_vld_nxt = 1'b0;
            end
          endcase
        end
      end
      ST_SEARCH: begin
        rd_en       = rd_go;
        chk_vld_nxt = rd_go;
        chk_idx_nxt = idx_r;
        if (rd_go) begin
          idx_nxt = idx_r + CW'(1);
        end
        if (hit) begin
          // Restart the walk one place above the match
          rd_en       = 1'b0;
          chk_vld_nxt = 1'b0;
          pos_nxt     = chk_idx_r[AW-1:0];
          idx_nxt     = src_inc;
        end else if (miss) begin
          out_vld_nxt         = 1'b1;
          out_nxt.status      = STS_NOTFOUND;
          out_nxt.position    = '0;
          out_nxt.entry_value = key_r;
          out_nxt.count       = 4'(count_r);
          out_nxt.last        = 1'b1;
        end
      end
      ST_SHIFT: begin
        rd_en       = rd_go;
        chk_vld_nxt = rd_go;
        chk_idx_nxt = idx_r;
        if (rd_go) begin
          idx_nxt = idx_r + CW'(1);
        end
        // Move the entry just read down by one place
        if (chk_vld_r) begin
          wr_en   = 1'b1;
          wr_addr = src_dec[AW-1:0];
          wr_data = rd_data;
        end
        if (shift_end) begin
          count_nxt           = cnt_dec;
          out_vld_nxt         = 1'b1;
          out_nxt.status      = STS_DONE;
          out_nxt.position    = 3'(pos_r);
          out_nxt.entry_value = key_r;
          out_nxt.count       = 4'(cnt_dec);
          out_nxt.last        = 1'b1;
        end
      end
      ST_READ: begin
        rd_en       = rd_go;
        chk_vld_nxt = rd_go;
        chk_idx_nxt = idx_r;
        if (rd_go) begin
          idx_nxt = idx_r + CW'(1);
        end
        // Emit one entry a cycle
        if (chk_vld_r) begin
          out_vld_nxt         = 1'b1;
          out_nxt.status      = STS_READ;
          out_nxt.position    = 3'(chk_idx_r);
          out_nxt.entry_value = rd_data;
          out_nxt.count       = 4'(count_r);
          out_nxt.last        = chk_last;
        end
      end
      default: begin
        out_vld_nxt = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      count_r   <= '0;
      chk_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      chk_vld_r <= chk_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    key_r     <= key_nxt;
    idx_r     <= idx_nxt;
    chk_idx_r <= chk_idx_nxt;
    pos_r     <= pos_nxt;
    out_r     <= out_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_item  = out_r;

endmodule
